### design/fpavt_pkg.sv
// ----------------------------------------------------------------------------
// fpavt_pkg
// Shared constants, codes, types and helpers for the affine vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none

package fpavt_pkg;

    // Fixed-point format
    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned DATA_W    = 32;
    localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

    // Action codes
    localparam logic [2:0] ACT_IDENT     = 3'd0;
    localparam logic [2:0] ACT_WRITE     = 3'd1;
    localparam logic [2:0] ACT_TRANSLATE = 3'd2;
    localparam logic [2:0] ACT_SCALE     = 3'd3;
    localparam logic [2:0] ACT_VERTEX    = 3'd4;

    // Bookkeeping that travels with one multiply-accumulate term
    typedef struct packed {
        logic       vld;     // term present
        logic       first;   // first term of an element, clears accumulator
        logic       last;    // last term of an element, result ready
        logic       fin;     // last term of the whole operation
        logic       to_mem;  // result goes back into the matrix
        logic [3:0] idx;     // matrix entry or output column
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic [DATA_W-1:0] coef;  // second multiplier operand
    } term_t;

    // Finished element from the accumulator
    typedef struct packed {
        logic              vld;
        logic              fin;
        logic              to_mem;
        logic [3:0]        idx;
        logic [DATA_W-1:0] data;
    } res_t;

    // Arithmetic shift right by the fraction width
    function automatic logic [DATA_W-1:0] fx_asr(input logic [DATA_W-1:0] v);
        return DATA_W'($signed(v) >>> FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

### design/fpavt_in_if.sv
// ----------------------------------------------------------------------------
// fpavt_in_if
// Command channel: action plus element, index and coordinate payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpavt_in_if
    import fpavt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [1:0]        row_index;
    logic [1:0]        col_index;
    logic [DATA_W-1:0] element_value;
    logic [DATA_W-1:0] x_in;
    logic [DATA_W-1:0] y_in;
    logic [DATA_W-1:0] z_in;
    logic              last_vertex;

    modport source (
        output valid, action, row_index, col_index, element_value,
               x_in, y_in, z_in, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, action, row_index, col_index, element_value,
               x_in, y_in, z_in, last_vertex,
        output ready
    );
endinterface

`default_nettype wire

### design/fpavt_out_if.sv
// ----------------------------------------------------------------------------
// fpavt_out_if
// Result channel: transformed vertex coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpavt_out_if
    import fpavt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] world_x;
    logic [DATA_W-1:0] world_y;
    logic [DATA_W-1:0] world_z;
    logic              last_out;

    modport source (
        output valid, world_x, world_y, world_z, last_out,
        input  ready
    );

    modport sink (
        input  valid, world_x, world_y, world_z, last_out,
        output ready
    );
endinterface

`default_nettype wire

### design/fpavt_mat_mem.sv
// ----------------------------------------------------------------------------
// fpavt_mat_mem
// 16-entry matrix store, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as the identity.
// ----------------------------------------------------------------------------
`default_nettype none

module fpavt_mat_mem
    import fpavt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clr,
    input  wire logic              we,
    input  wire logic [3:0]        waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [3:0]        raddr,
    output      logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [16];
    logic [DATA_W-1:0] raw_reg;
    logic [15:0]       valid_reg;
    logic [15:0]       valid_next;
    logic              rd_valid_reg;
    logic              rd_diag_reg;

    // Storage and raw read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        raw_reg <= mem[raddr];
    end

    // Valid bits: identity action drops them all
    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = '0;
        end
        else if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_diag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[raddr];
            rd_diag_reg  <= (raddr[3:2] == raddr[1:0]);
        end
    end

    // Unwritten entries read as identity
    assign rdata = rd_valid_reg ? raw_reg : (rd_diag_reg ? FX_ONE : '0);

endmodule

`default_nettype wire

### design/fpavt_seq.sv
// ----------------------------------------------------------------------------
// fpavt_seq
// Term sequencer: walks the elements of one operation and issues one
// multiply-accumulate term per cycle (matrix address plus coefficient).
// ----------------------------------------------------------------------------
`default_nettype none

module fpavt_seq
    import fpavt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        op,
    input  wire logic [DATA_W-1:0] x_in,
    input  wire logic [DATA_W-1:0] y_in,
    input  wire logic [DATA_W-1:0] z_in,
    output      logic [3:0]        rd_addr,
    output      term_t             term
);

    logic              active_reg;
    logic [2:0]        op_reg;
    logic [3:0]        elem_reg;
    logic [1:0]        term_reg;
    logic [DATA_W-1:0] cx_reg;
    logic [DATA_W-1:0] cy_reg;
    logic [DATA_W-1:0] cz_reg;

    logic [1:0]        row;
    logic [1:0]        col;
    logic              term_last;
    logic              elem_last;

    function automatic logic [DATA_W-1:0] coord_sel(
        input logic [1:0]        sel,
        input logic [DATA_W-1:0] cx,
        input logic [DATA_W-1:0] cy,
        input logic [DATA_W-1:0] cz
    );
        logic [DATA_W-1:0] v;
        case (sel)
            2'd0:    v = cx;
            2'd1:    v = cy;
            2'd2:    v = cz;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign row = elem_reg[3:2];
    assign col = elem_reg[1:0];

    // Term decode per operation
    always_comb
    begin
        rd_addr   = elem_reg;
        term.coef = FX_ONE;
        term_last = 1'b1;
        elem_last = (elem_reg == 4'd15);
        case (op_reg)
            ACT_TRANSLATE:
            begin
                // M*T: m[r][c]*ONE + m[r][3]*(t_c << F); last column one term
                term_last = (col == 2'd3) || (term_reg == 2'd1);
                if (term_reg != 2'd0)
                begin
                    rd_addr   = {row, 2'd3};
                    term.coef = coord_sel(col, cx_reg, cy_reg, cz_reg) << FRAC_BITS;
                end
            end
            ACT_SCALE:
            begin
                // S*M: row r scaled by asr(s_r), last row by ONE
                if (row != 2'd3)
                begin
                    term.coef = fx_asr(coord_sel(row, cx_reg, cy_reg, cz_reg));
                end
            end
            ACT_VERTEX:
            begin
                // Column c: x*m0c + y*m1c + z*m2c + m3c
                rd_addr   = {term_reg, col};
                term.coef = (term_reg == 2'd3) ? DATA_W'(1)
                                               : coord_sel(term_reg, cx_reg, cy_reg, cz_reg);
                term_last = (term_reg == 2'd3);
                elem_last = (elem_reg == 4'd2);
            end
            default:
            begin
                term_last = 1'b1;
            end
        endcase
        term.tag.vld    = active_reg;
        term.tag.first  = (term_reg == 2'd0);
        term.tag.last   = term_last;
        term.tag.fin    = term_last && elem_last;
        term.tag.to_mem = (op_reg != ACT_VERTEX);
        term.tag.idx    = elem_reg;
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            op_reg     <= ACT_IDENT;
            elem_reg   <= '0;
            term_reg   <= '0;
        end
        else if (start && !active_reg)
        begin
            active_reg <= 1'b1;
            op_reg     <= op;
            elem_reg   <= '0;
            term_reg   <= '0;
        end
        else if (active_reg)
        begin
            if (term_last)
            begin
                term_reg <= '0;
                if (elem_last)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    elem_reg <= elem_reg + 4'd1;
                end
            end
            else
            begin
                term_reg <= term_reg + 2'd1;
            end
        end
    end

    // Operand capture
    always_ff @(posedge clk)
    begin
        if (start && !active_reg)
        begin
            cx_reg <= x_in;
            cy_reg <= y_in;
            cz_reg <= z_in;
        end
    end

endmodule

`default_nettype wire

### design/fpavt_mac.sv
// ----------------------------------------------------------------------------
// fpavt_mac
// Shared multiply-accumulate unit: one 32x32 low product per cycle,
// registered, then summed; element result is shifted right by the
// fraction width.
// ----------------------------------------------------------------------------
`default_nettype none

module fpavt_mac
    import fpavt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire term_t             term,
    input  wire logic [DATA_W-1:0] rdata,
    output      res_t              res
);

    term_t             s1_reg;
    tag_t              s2_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_sum;

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= term;
            s2_reg <= s1_reg.tag;
        end
    end

    // Accumulate the registered product
    assign acc_sum = (s2_reg.first ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= DATA_W'(rdata * s1_reg.coef);
        if (s2_reg.vld)
        begin
            acc_reg <= acc_sum;
        end
    end

    always_comb
    begin
        res.vld    = s2_reg.vld && s2_reg.last;
        res.fin    = s2_reg.vld && s2_reg.fin;
        res.to_mem = s2_reg.to_mem;
        res.idx    = s2_reg.idx;
        res.data   = fx_asr(acc_sum);
    end

endmodule

`default_nettype wire

### design/fixed_point_affine_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// fixed_point_affine_vertex_transform_core
// 4x4 fixed-point matrix with identity, element write, translate, scale
// and vertex transform, all products through one shared MAC unit.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  req     | in  | action, row/col index, element value, x/y/z, last flag
//  rsp     | out | world_x, world_y, world_z, last_out (vertex actions only)
//
//  Identity, element write and unused codes leave the core idle and ready.
//  Scale issues 16 MAC terms, translate 28, vertex 12: one MAC term
//  per cycle through the single multiplier, each term read, multiplied, added.
//  Reset leaves the matrix at the identity with no sweep needed.
//  A waiting result does not block non-vertex actions; a vertex finishing
//  while the previous result is still unread holds until rsp is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_affine_vertex_transform_core
    import fpavt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fpavt_in_if.sink  req,
    fpavt_out_if.source rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              accept;
    logic              start;
    logic              out_load;

    logic              last_reg;
    logic [DATA_W-1:0] res_x_reg;
    logic [DATA_W-1:0] res_y_reg;
    logic [DATA_W-1:0] res_z_reg;
    logic              out_vld_reg;
    logic [DATA_W-1:0] out_x_reg;
    logic [DATA_W-1:0] out_y_reg;
    logic [DATA_W-1:0] out_z_reg;
    logic              out_last_reg;

    logic              mem_clr;
    logic              mem_we;
    logic [3:0]        mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [3:0]        rd_addr;
    logic [DATA_W-1:0] rdata;
    term_t             term;
    res_t              res;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign start     = accept && ((req.action == ACT_TRANSLATE) ||
                                  (req.action == ACT_SCALE) ||
                                  (req.action == ACT_VERTEX));
    assign out_load  = (state_reg == ST_PUSH) && (!out_vld_reg || rsp.ready);

    // Matrix write port: direct element write or MAC result
    always_comb
    begin
        mem_clr   = accept && (req.action == ACT_IDENT);
        mem_we    = 1'b0;
        mem_waddr = res.idx;
        mem_wdata = res.data;
        if (accept && (req.action == ACT_WRITE))
        begin
            mem_we    = 1'b1;
            mem_waddr = {req.row_index, req.col_index};
            mem_wdata = req.element_value;
        end
        else if (res.vld && res.to_mem)
        begin
            mem_we = 1'b1;
        end
    end

    fpavt_mat_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mem_clr),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    fpavt_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .op      (req.action),
        .x_in    (req.x_in),
        .y_in    (req.y_in),
        .z_in    (req.z_in),
        .rd_addr (rd_addr),
        .term    (term)
    );

    fpavt_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .term  (term),
        .rdata (rdata),
        .res   (res)
    );

    // Control sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (res.fin)
                begin
                    state_next = res.to_mem ? ST_IDLE : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Vertex result collection and output register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            last_reg <= req.last_vertex;
        end
        if (res.vld && !res.to_mem)
        begin
            case (res.idx[1:0])
                2'd0:    res_x_reg <= res.data;
                2'd1:    res_y_reg <= res.data;
                default: res_z_reg <= res.data;
            endcase
        end
        if (out_load)
        begin
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_y_reg;
            out_z_reg    <= res_z_reg;
            out_last_reg <= last_reg;
        end
    end

    assign rsp.valid    = out_vld_reg;
    assign rsp.world_x  = out_x_reg;
    assign rsp.world_y  = out_y_reg;
    assign rsp.world_z  = out_z_reg;
    assign rsp.last_out = out_last_reg;

endmodule

`default_nettype wire

### design/fpavt_chk.sv
// ----------------------------------------------------------------------------
// fpavt_chk
// Port-level checks for the vertex transform core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpavt_chk
    import fpavt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [2:0]        action,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [DATA_W-1:0] world_x,
    input wire logic [DATA_W-1:0] world_y,
    input wire logic [DATA_W-1:0] world_z,
    input wire logic              last_out
);

    logic in_beat;

    assign in_beat = in_valid && in_ready;

    // A stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(world_x) && $stable(world_y) &&
                                    $stable(world_z) && $stable(last_out))
        else $error("result payload changed while stalled");

    // Vertex work occupies the shared unit and holds ready low after the beat
    a_vertex_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && (action == ACT_VERTEX) |=> !in_ready ##1 !in_ready)
        else $error("ready again too early after vertex beat");

    // Identity and element write do not hold the input: ready stays up after the beat
    a_simple_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && (action == ACT_IDENT || action == ACT_WRITE) |=> in_ready)
        else $error("single-cycle action held the input");

endmodule

bind fixed_point_affine_vertex_transform_core fpavt_chk u_fpavt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .action    (req.action),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .world_x   (rsp.world_x),
    .world_y   (rsp.world_y),
    .world_z   (rsp.world_z),
    .last_out  (rsp.last_out)
);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the affine vertex transform core. Directed and
// random command streams build up the master matrix. A shadow copy of the
// matrix inside the bench predicts every transformed vertex. Each result
// beat is checked field by field, in order, against those predictions.
// ----------------------------------------------------------------------------
module tb_top;
    import fpavt_pkg::*;

    // Action codes the core ignores
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned TAIL_CYCLES  = 48;

    typedef logic [DATA_W-1:0] word_t;
    typedef word_t mat_t [16];

    typedef struct {
        logic [2:0] action;
        logic [1:0] row_index;
        logic [1:0] col_index;
        word_t      element_value;
        word_t      x_in;
        word_t      y_in;
        word_t      z_in;
        logic       last_vertex;
        bit         wait_drain;   // hold this beat until all vertices are back
    } cmd_t;

    typedef struct {
        word_t world_x;
        word_t world_y;
        word_t world_z;
        logic  last_out;
    } coord_t;

    logic clk;
    logic rst_n;

    fpavt_in_if  req_if ();
    fpavt_out_if rsp_if ();

    fixed_point_affine_vertex_transform_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    mat_t        shadow_m;
    cmd_t        cmd_backlog [$];
    coord_t      world_q [$];
    cmd_t        cur_cmd;
    int unsigned n_cmds_total  = 0;
    int unsigned n_cmds_taken  = 0;
    int unsigned n_vertex_sent = 0;
    int unsigned n_vertex_seen = 0;
    int unsigned n_errors      = 0;
    int unsigned idle_cycles   = 0;
    int unsigned tx_gap        = 0;
    int unsigned rx_stall      = 0;
    bit          calm_tx       = 1'b0;
    bit          calm_rx       = 1'b0;

    // ------------------------------------------------------------------------
    // Matrix arithmetic
    // ------------------------------------------------------------------------
    function automatic word_t asr_frac(input word_t v);
        return {{FRAC_BITS{v[DATA_W-1]}}, v[DATA_W-1:FRAC_BITS]};
    endfunction

    function automatic mat_t unit_matrix();
        mat_t m;
        foreach (m[i])
            m[i] = (i % 5 == 0) ? FX_ONE : '0;
        return m;
    endfunction

    // Row-major product, every sum wrapped to 32 bits before the shift
    function automatic mat_t mat_product(input mat_t a, input mat_t b);
        mat_t  p;
        word_t acc;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                acc = '0;
                for (int k = 0; k < 4; k++)
                    acc = acc + a[r*4+k] * b[k*4+c];
                p[r*4+c] = asr_frac(acc);
            end
        end
        return p;
    endfunction

    // Update the shadow matrix for one accepted command; queue vertex results
    task automatic apply_command(input cmd_t c);
        mat_t   aux;
        coord_t res;
        word_t  acc [3];
        aux = unit_matrix();
        case (c.action)
            ACT_IDENT:
                shadow_m = unit_matrix();
            ACT_WRITE:
                shadow_m[{c.row_index, c.col_index}] = c.element_value;
            ACT_TRANSLATE:
            begin
                aux[12] = c.x_in << FRAC_BITS;
                aux[13] = c.y_in << FRAC_BITS;
                aux[14] = c.z_in << FRAC_BITS;
                shadow_m = mat_product(shadow_m, aux);
            end
            ACT_SCALE:
            begin
                aux[0]  = asr_frac(c.x_in);
                aux[5]  = asr_frac(c.y_in);
                aux[10] = asr_frac(c.z_in);
                shadow_m = mat_product(aux, shadow_m);
            end
            ACT_VERTEX:
            begin
                for (int k = 0; k < 3; k++)
                    acc[k] = asr_frac(c.x_in * shadow_m[k] + c.y_in * shadow_m[4+k]
                                      + c.z_in * shadow_m[8+k] + shadow_m[12+k]);
                res.world_x  = acc[0];
                res.world_y  = acc[1];
                res.world_z  = acc[2];
                res.last_out = c.last_vertex;
                world_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mix of full-range words, extremes, small integers and fixed-point values
    function automatic word_t any_word();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7fff_ffff;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            3, 4, 5: return word_t'($urandom_range(0, 8191)) - word_t'(4096);
            default: return word_t'($urandom_range(0, 2047)) - word_t'(1024);
        endcase
    endfunction

    function automatic cmd_t rand_cmd(input logic [2:0] action);
        cmd_t c;
        c.action        = action;
        c.row_index     = 2'($urandom_range(0, 3));
        c.col_index     = 2'($urandom_range(0, 3));
        c.element_value = $urandom;
        c.x_in          = any_word();
        c.y_in          = any_word();
        c.z_in          = any_word();
        c.last_vertex   = 1'($urandom_range(0, 1));
        c.wait_drain    = 1'b0;
        return c;
    endfunction

    function automatic cmd_t mk_cmd(input logic [2:0] action, input logic [1:0] row_index,
                                    input logic [1:0] col_index, input word_t element_value,
                                    input word_t x_in, input word_t y_in, input word_t z_in,
                                    input logic last_vertex);
        cmd_t c;
        c.action        = action;
        c.row_index     = row_index;
        c.col_index     = col_index;
        c.element_value = element_value;
        c.x_in          = x_in;
        c.y_in          = y_in;
        c.z_in          = z_in;
        c.last_vertex   = last_vertex;
        c.wait_drain    = 1'b0;
        return c;
    endfunction

    task automatic check_field(input string name, input word_t want, input word_t got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Command driver: one beat from the backlog, then a drawn gap
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        int unsigned sent_now;
        if (rst_n)
        begin
            sent_now = n_vertex_sent;
            if (req_if.valid && req_if.ready)
            begin
                apply_command(cur_cmd);
                n_cmds_taken <= n_cmds_taken + 1;
                if (cur_cmd.action == ACT_VERTEX)
                    sent_now++;
                n_vertex_sent <= sent_now;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (tx_gap != 0)
                begin
                    req_if.valid <= 1'b0;
                    tx_gap--;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].wait_drain && sent_now != n_vertex_seen))
                begin
                    cur_cmd = cmd_backlog.pop_front();
                    req_if.valid         <= 1'b1;
                    req_if.action        <= cur_cmd.action;
                    req_if.row_index     <= cur_cmd.row_index;
                    req_if.col_index     <= cur_cmd.col_index;
                    req_if.element_value <= cur_cmd.element_value;
                    req_if.x_in          <= cur_cmd.x_in;
                    req_if.y_in          <= cur_cmd.y_in;
                    req_if.z_in          <= cur_cmd.z_in;
                    req_if.last_vertex   <= cur_cmd.last_vertex;
                    // long runs without gaps now and then
                    if ($urandom_range(0, 39) == 0)
                        calm_tx = !calm_tx;
                    tx_gap = calm_tx ? 0 : $urandom_range(0, 8);
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each beat, then stall for a drawn count
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        coord_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                n_vertex_seen <= n_vertex_seen + 1;
                if (world_q.size() == 0)
                begin
                    $error("result beat with nothing expected: world_x %0h", rsp_if.world_x);
                    n_errors++;
                end
                else
                begin
                    want = world_q.pop_front();
                    check_field("world_x", want.world_x, rsp_if.world_x);
                    check_field("world_y", want.world_y, rsp_if.world_y);
                    check_field("world_z", want.world_z, rsp_if.world_z);
                    check_field("last_out", word_t'(want.last_out), word_t'(rsp_if.last_out));
                end
                if ($urandom_range(0, 39) == 0)
                    calm_rx = !calm_rx;
                rx_stall = calm_rx ? 0 : $urandom_range(0, 8);
                rsp_if.ready <= (rx_stall == 0);
            end
            else if (rx_stall != 0)
            begin
                rx_stall--;
                rsp_if.ready <= (rx_stall == 0);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any beat on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $error("no beat accepted for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        cmd_t        c;
        cmd_t        obj [$];
        int unsigned n_real;
        int unsigned n_vtx;
        bit          first_obj;

        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.action        = ACT_IDENT;
        req_if.row_index     = '0;
        req_if.col_index     = '0;
        req_if.element_value = '0;
        req_if.x_in          = '0;
        req_if.y_in          = '0;
        req_if.z_in          = '0;
        req_if.last_vertex   = 1'b0;
        rsp_if.ready         = 1'b0;
        shadow_m             = unit_matrix();

        // identity after reset passes coordinates through; extreme coordinates
        cmd_backlog.push_back(mk_cmd(ACT_VERTEX, 2'd0, 2'd0, '0,
                                     word_t'(1), word_t'(2), word_t'(3), 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_VERTEX, 2'd3, 2'd3, '1,
                                     32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1));
        // element writes at the index corners with extreme values
        cmd_backlog.push_back(mk_cmd(ACT_WRITE, 2'd0, 2'd0, 32'h7fff_ffff, '0, '0, '0, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_WRITE, 2'd3, 2'd3, 32'h8000_0000, '1, '1, '1, 1'b1));
        cmd_backlog.push_back(mk_cmd(ACT_WRITE, 2'd1, 2'd2, 32'hffff_ffff, '0, '0, '0, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_WRITE, 2'd2, 2'd1, 32'h0000_0180, '0, '0, '0, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_VERTEX, 2'd0, 2'd0, '0,
                                     32'h0001_0000, 32'hffff_ff00, 32'h1234_5678, 1'b1));
        // translation whose shift wraps, then a sane one
        cmd_backlog.push_back(mk_cmd(ACT_IDENT, 2'd0, 2'd0, '0, '0, '0, '0, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_TRANSLATE, 2'd0, 2'd0, '0,
                                     32'h7fff_ffff, 32'h8000_0000, '0, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_VERTEX, 2'd0, 2'd0, '0, '0, '0, '0, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_TRANSLATE, 2'd0, 2'd0, '0,
                                     word_t'(10), word_t'(-20), word_t'(30), 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_VERTEX, 2'd0, 2'd0, '0,
                                     word_t'(1), word_t'(1), word_t'(1), 1'b1));
        // scale by extremes and by a factor that shifts down to zero
        cmd_backlog.push_back(mk_cmd(ACT_IDENT, 2'd0, 2'd0, '0, '0, '0, '0, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_SCALE, 2'd0, 2'd0, '0,
                                     32'h7fff_ffff, 32'h8000_0000, 32'h0000_00ff, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_VERTEX, 2'd0, 2'd0, '0,
                                     word_t'(256), word_t'(-256), word_t'(5), 1'b1));
        // scale by 2.0, -1.0 and one LSB
        cmd_backlog.push_back(mk_cmd(ACT_IDENT, 2'd0, 2'd0, '0, '0, '0, '0, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_SCALE, 2'd0, 2'd0, '0,
                                     32'h0002_0000, 32'hffff_0000, 32'h0000_0100, 1'b0));
        cmd_backlog.push_back(mk_cmd(ACT_VERTEX, 2'd0, 2'd0, '0,
                                     word_t'(100), word_t'(200), word_t'(300), 1'b0));
        // ignored codes must leave the matrix alone
        for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            cmd_backlog.push_back(rand_cmd(3'(a)));
        cmd_backlog.push_back(mk_cmd(ACT_VERTEX, 2'd0, 2'd0, '0,
                                     word_t'(7), word_t'(8), word_t'(9), 1'b1));

        // Random objects: set up a matrix, then stream a vertex list
        n_real    = 0;
        first_obj = 1'b1;
        while (n_real < RANDOM_ITEMS)
        begin
            obj.delete();
            if ($urandom_range(0, 7) != 0)
                obj.push_back(rand_cmd(ACT_IDENT));
            repeat ($urandom_range(0, 3))
            begin
                c = rand_cmd(ACT_WRITE);
                if ($urandom_range(0, 3) != 0)
                    c.element_value = word_t'($urandom_range(0, 1023)) - word_t'(512);
                obj.push_back(c);
            end
            repeat ($urandom_range(0, 2))
            begin
                if ($urandom_range(0, 1) != 0)
                    obj.push_back(rand_cmd(ACT_TRANSLATE));
                else
                begin
                    c = rand_cmd(ACT_SCALE);
                    // mostly factors between -1.0 and 2.0
                    if ($urandom_range(0, 4) != 0)
                    begin
                        c.x_in = (word_t'($urandom_range(0, 768)) - word_t'(256)) << FRAC_BITS;
                        c.y_in = (word_t'($urandom_range(0, 768)) - word_t'(256)) << FRAC_BITS;
                        c.z_in = (word_t'($urandom_range(0, 768)) - word_t'(256)) << FRAC_BITS;
                    end
                    obj.push_back(c);
                end
            end
            n_vtx = $urandom_range(1, 8);
            for (int i = 0; i < n_vtx; i++)
            begin
                c = rand_cmd(ACT_VERTEX);
                c.last_vertex = (i == n_vtx - 1);
                obj.push_back(c);
            end
            // noise: a stray ignored code or a list with no final marker
            if ($urandom_range(0, 9) == 0)
                obj.insert($urandom_range(0, obj.size()),
                           rand_cmd(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI))));
            if ($urandom_range(0, 9) == 0)
                obj[obj.size()-1].last_vertex = 1'b0;
            obj[0].wait_drain = first_obj || ($urandom_range(0, 24) == 0);
            first_obj = 1'b0;
            foreach (obj[i])
            begin
                cmd_backlog.push_back(obj[i]);
                if (obj[i].action <= ACT_VERTEX)
                    n_real++;
            end
        end
        n_cmds_total = cmd_backlog.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (n_cmds_taken != n_cmds_total || n_vertex_sent > n_vertex_seen)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (world_q.size() != 0)
        begin
            $error("%0d expected vertex results never arrived", world_q.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
